// ===== rtl/core/tlrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_pkg
// Shared types and constants for the text line row segmenter.
// ----------------------------------------------------------------------------
package tlrs_pkg;

    // frame geometry
    localparam int MAX_ROWS = 2048;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CNT_W    = $clog2(MAX_ROWS + 1);
    localparam logic [CNT_W-1:0] MAX_ROWS_C = CNT_W'(MAX_ROWS);

    // register file
    localparam int PIX_W     = 8;
    localparam int SPAN_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_DARK_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN_INNER = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN_FINAL = CFG_IDX_W'(2);

    localparam logic [PIX_W-1:0]  RST_DARK_THRESHOLD = PIX_W'(100);
    localparam logic [SPAN_W-1:0] RST_MIN_SPAN_INNER = SPAN_W'(7);
    localparam logic [SPAN_W-1:0] RST_MIN_SPAN_FINAL = SPAN_W'(5);
    localparam logic [PIX_W-1:0]  PIX_WHITE          = PIX_W'(255);

    // request queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // everything one accepted pixel produces: a closed segment and/or a frame result
    typedef struct packed {
        logic              inner_valid;
        logic [ROW_W-1:0]  inner_top;
        logic [CNT_W-1:0]  inner_height;
        logic              frame_end;
        logic              fin_valid;
        logic [ROW_W-1:0]  fin_top;
        logic [CNT_W-1:0]  fin_height;
    } t_seg_rec;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

// ===== rtl/core/tlrs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_front
// Accepts pixels, tracks the darkest pixel per row, classifies rows and
// updates the current run; emits a request per frame and per long closed run.
// ----------------------------------------------------------------------------
module tlrs_front
    import tlrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_row_end,
    input  logic                 i_frame_end,
    input  t_q_status            i_q_status,
    output logic                 o_stall,
    output logic                 o_push,
    output t_seg_rec             o_rec
);

    logic [PIX_W-1:0]  r_thr;
    logic [SPAN_W-1:0] r_min_inner;
    logic [SPAN_W-1:0] r_min_final;

    logic [CNT_W-1:0]  r_row_idx, n_row_idx;
    logic [PIX_W-1:0]  r_darkest, n_darkest;
    logic [ROW_W-1:0]  r_first, n_first;
    logic [ROW_W-1:0]  r_last, n_last;

    logic              accept;
    logic              over;
    logic              row_close;
    logic              row_dark;
    logic              run_cont;
    logic              inner_hit;
    logic              fin_hit;
    logic [PIX_W-1:0]  darkest_nx;
    logic [ROW_W-1:0]  cur_row;
    logic [ROW_W-1:0]  span_in;
    logic [ROW_W-1:0]  span_fin;
    logic [ROW_W-1:0]  in_top;
    logic [CNT_W-1:0]  in_end;
    logic [ROW_W-1:0]  fin_top;
    logic [CNT_W-1:0]  fin_end;

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;

    always_comb begin
        darkest_nx = (i_pixel < r_darkest) ? i_pixel : r_darkest;
        over       = (r_row_idx >= MAX_ROWS_C);
        row_close  = accept && !over && (i_row_end || i_frame_end);
        // 255 - x is the bitwise inverse on eight bits
        row_dark   = (~darkest_nx) > r_thr;
        cur_row    = r_row_idx[ROW_W-1:0];
        run_cont   = (({1'b0, r_last} + CNT_W'(1)) == r_row_idx);
        span_in    = r_last - r_first;
        inner_hit  = row_close && row_dark && !run_cont && (r_last >= r_first) &&
                     ({1'b0, span_in} > r_min_inner);
        in_top     = (r_first != '0) ? (r_first - ROW_W'(1)) : r_first;
        in_end     = {1'b0, r_last} + CNT_W'(1);

        n_first = r_first;
        n_last  = r_last;
        if (row_close && row_dark) begin
            if (run_cont) begin
                n_last = cur_row;
            end else begin
                n_first = cur_row;
                n_last  = cur_row;
            end
        end
        n_row_idx = row_close ? (r_row_idx + CNT_W'(1)) : r_row_idx;
        n_darkest = r_darkest;
        if (accept && !over) begin
            n_darkest = row_close ? PIX_WHITE : darkest_nx;
        end

        // frame result works on the run as left by this pixel
        span_fin = n_last - n_first;
        fin_hit  = (n_last >= n_first) && ({1'b0, span_fin} > r_min_final);
        fin_top  = (n_first != '0) ? (n_first - ROW_W'(1)) : n_first;
        fin_end  = {1'b0, n_last};
        if ((n_row_idx != '0) && (fin_end < (n_row_idx - CNT_W'(1)))) begin
            fin_end = fin_end + CNT_W'(1);
        end

        o_rec.inner_valid  = inner_hit;
        o_rec.inner_top    = in_top;
        o_rec.inner_height = in_end - {1'b0, in_top};
        o_rec.frame_end    = i_frame_end;
        o_rec.fin_valid    = fin_hit;
        o_rec.fin_top      = fin_hit ? fin_top : '0;
        o_rec.fin_height   = fin_hit ? (fin_end - {1'b0, fin_top}) : '0;
        o_push             = accept && (inner_hit || i_frame_end);

        if (accept && i_frame_end) begin
            n_row_idx = '0;
            n_darkest = PIX_WHITE;
            n_first   = '0;
            n_last    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_idx <= '0;
            r_darkest <= PIX_WHITE;
            r_first   <= '0;
            r_last    <= '0;
        end else begin
            r_row_idx <= n_row_idx;
            r_darkest <= n_darkest;
            r_first   <= n_first;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= RST_DARK_THRESHOLD;
            r_min_inner <= RST_MIN_SPAN_INNER;
            r_min_final <= RST_MIN_SPAN_FINAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DARK_THRESHOLD: r_thr       <= i_cfg_data[PIX_W-1:0];
                CFG_MIN_SPAN_INNER: r_min_inner <= i_cfg_data[SPAN_W-1:0];
                CFG_MIN_SPAN_FINAL: r_min_final <= i_cfg_data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_row_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_idx <= MAX_ROWS_C)
        else $error("row index past frame limit");

    a_frame_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_end) |=> (r_row_idx == '0 && r_darkest == PIX_WHITE))
        else $error("frame state not cleared after frame end");
`endif

endmodule

// ===== rtl/core/tlrs_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_queue
// Short request queue decoupling the pixel front from the result back.
// ----------------------------------------------------------------------------
module tlrs_queue
    import tlrs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_seg_rec  i_rec,
    input  logic      i_pop,
    output t_seg_rec  o_head,
    output t_q_status o_status
);

    t_seg_rec             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count overflow");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("request pushed into full queue");
`endif

endmodule

// ===== rtl/core/tlrs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlrs_back
// Drains queued requests into the output register, splitting a request that
// holds both a closed segment and a frame result into two results.
// ----------------------------------------------------------------------------
module tlrs_back
    import tlrs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_seg_rec         i_head,
    input  t_q_status        i_q_status,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output logic             o_segment_valid,
    output logic [ROW_W-1:0] o_segment_top,
    output logic [CNT_W-1:0] o_segment_height,
    output logic             o_frame_done
);

    logic             r_out_valid;
    logic             r_seg_valid;
    logic [ROW_W-1:0] r_top;
    logic [CNT_W-1:0] r_height;
    logic             r_done;
    logic             r_pend;
    logic             r_fin_valid;
    logic [ROW_W-1:0] r_fin_top;
    logic [CNT_W-1:0] r_fin_height;
    logic             out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = out_free && !r_pend && !i_q_status.empty;

    assign o_valid          = r_out_valid;
    assign o_segment_valid  = r_seg_valid;
    assign o_segment_top    = r_top;
    assign o_segment_height = r_height;
    assign o_frame_done     = r_done;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (out_free) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_q_status.empty) begin
                r_out_valid <= 1'b1;
                r_pend      <= i_head.inner_valid && i_head.frame_end;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend) begin
                r_seg_valid <= r_fin_valid;
                r_top       <= r_fin_top;
                r_height    <= r_fin_height;
                r_done      <= 1'b1;
            end else if (i_head.inner_valid) begin
                r_seg_valid  <= 1'b1;
                r_top        <= i_head.inner_top;
                r_height     <= i_head.inner_height;
                r_done       <= 1'b0;
                r_fin_valid  <= i_head.fin_valid;
                r_fin_top    <= i_head.fin_top;
                r_fin_height <= i_head.fin_height;
            end else begin
                r_seg_valid <= i_head.fin_valid;
                r_top       <= i_head.fin_top;
                r_height    <= i_head.fin_height;
                r_done      <= 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_pend_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("pending frame result without a result in the output register");

    a_pend_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !o_pop)
        else $error("queue popped while frame result pending");
`endif

endmodule

// ===== rtl/core/text_line_row_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_row_segmenter
// Finds horizontal text line segments in a grayscale raster streamed in
// row order and reports each as a padded top row and height.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_pixel, i_row_end, i_frame_end;
//   one pixel is taken per clock while o_stall is low. o_stall rises only
//   when the four-entry request queue is full.
//   Output channel: o_valid / i_stall with o_segment_valid, o_segment_top,
//   o_segment_height, o_frame_done. Every frame ends in one result with
//   o_frame_done set; a row end that closes a long enough run gives one more
//   result before it.
//   A request is written into the queue and then into the output register;
//   a frame end that also closes a run gives two results, the segment first.
//   Throughput: one pixel per cycle while o_stall is low. When the receiver
//   stalls, the output register holds its result and the queue absorbs up to
//   four further requests before o_stall is raised. Configuration (i_cfg_we,
//   i_cfg_index, i_cfg_data) must be written while idle (not enforced).
//   Synchronous reset restores register defaults and clears frame state.
// ----------------------------------------------------------------------------
module text_line_row_segmenter
    import tlrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_row_end,
    input  logic                 i_frame_end,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_segment_valid,
    output logic [ROW_W-1:0]     o_segment_top,
    output logic [CNT_W-1:0]     o_segment_height,
    output logic                 o_frame_done
);

    logic      push;
    logic      pop;
    t_seg_rec  rec;
    t_seg_rec  head;
    t_q_status q_status;

    tlrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_pixel     (i_pixel),
        .i_row_end   (i_row_end),
        .i_frame_end (i_frame_end),
        .i_q_status  (q_status),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_rec       (rec)
    );

    tlrs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (rec),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    tlrs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_q_status       (q_status),
        .i_stall          (i_stall),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .o_segment_valid  (o_segment_valid),
        .o_segment_top    (o_segment_top),
        .o_segment_height (o_segment_height),
        .o_frame_done     (o_frame_done)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_line_row_segmenter. Pixels are streamed as
// frames of dark and bright rows. A behavioral copy of the row classifier
// and run tracker predicts every segment and frame result, and each result
// taken from the block is compared field by field in arrival order. Receiver
// stalls and sender gaps change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    import tlrs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(3);
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_PIXELS = 150;

    typedef struct packed {
        logic             seg_valid;
        logic [ROW_W-1:0] top;
        logic [CNT_W-1:0] height;
        logic             done;
    } t_seg_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic [PIX_W-1:0]     i_pixel     = '0;
    logic                 i_row_end   = 1'b0;
    logic                 i_frame_end = 1'b0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_segment_valid;
    logic [ROW_W-1:0]     o_segment_top;
    logic [CNT_W-1:0]     o_segment_height;
    logic                 o_frame_done;

    // predictor copy of registers and frame state
    logic [PIX_W-1:0]  dark_thr;
    logic [SPAN_W-1:0] span_inner;
    logic [SPAN_W-1:0] span_final;
    logic [CNT_W-1:0]  rows_done;
    logic [PIX_W-1:0]  row_min;
    logic [ROW_W-1:0]  run_top_row;
    logic [ROW_W-1:0]  run_bottom_row;

    t_seg_result expected_segments[$];
    int mismatch_count     = 0;
    int pixels_sent        = 0;
    int cycle_count        = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    text_line_row_segmenter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_pixel         (i_pixel),
        .i_row_end       (i_row_end),
        .i_frame_end     (i_frame_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_valid (o_segment_valid),
        .o_segment_top   (o_segment_top),
        .o_segment_height(o_segment_height),
        .o_frame_done    (o_frame_done)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL text_line_row_segmenter");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_seg_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_segments.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: valid=%0d top=%0d height=%0d done=%0d",
                             o_segment_valid, o_segment_top, o_segment_height,
                             o_frame_done);
                mismatch_count++;
            end else begin
                want = expected_segments.pop_front();
                if (o_segment_valid !== want.seg_valid || o_segment_top !== want.top ||
                    o_segment_height !== want.height || o_frame_done !== want.done) begin
                    if (mismatch_count < 10)
                        $display({"mismatch: expected valid=%0d top=%0d height=%0d done=%0d,",
                                  " got valid=%0d top=%0d height=%0d done=%0d"},
                                 want.seg_valid, want.top, want.height, want.done,
                                 o_segment_valid, o_segment_top, o_segment_height,
                                 o_frame_done);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void clear_frame_state();
        rows_done      = '0;
        row_min        = PIX_WHITE;
        run_top_row    = '0;
        run_bottom_row = '0;
    endfunction

    function automatic void expect_segment(logic seg_valid, int top, int height, logic done);
        t_seg_result res;
        res.seg_valid = seg_valid;
        res.top       = ROW_W'(top);
        res.height    = CNT_W'(height);
        res.done      = done;
        expected_segments.insert(expected_segments.size(), res);
    endfunction

    // row classification and run tracking for one accepted pixel
    function automatic void predict_pixel(logic [PIX_W-1:0] pix, logic row_end,
                                          logic frame_end);
        int row;
        int first_row;
        int last_row;
        int seg_start;
        int seg_end;
        if (rows_done < MAX_ROWS_C) begin
            if (pix < row_min)
                row_min = pix;
            if (row_end || frame_end) begin
                row = int'(rows_done);
                if (255 - int'(row_min) > int'(dark_thr)) begin
                    first_row = int'(run_top_row);
                    last_row  = int'(run_bottom_row);
                    if (last_row + 1 == row) begin
                        run_bottom_row = ROW_W'(row);
                    end else begin
                        if (last_row >= first_row && last_row - first_row > int'(span_inner)) begin
                            seg_start = (first_row > 0) ? first_row - 1 : 0;
                            seg_end   = last_row + 1;
                            expect_segment(1'b1, seg_start, seg_end - seg_start, 1'b0);
                        end
                        run_top_row    = ROW_W'(row);
                        run_bottom_row = ROW_W'(row);
                    end
                end
                row_min   = PIX_WHITE;
                rows_done = rows_done + CNT_W'(1);
            end
        end
        if (frame_end) begin
            first_row = int'(run_top_row);
            last_row  = int'(run_bottom_row);
            if (last_row >= first_row && last_row - first_row > int'(span_final)) begin
                seg_start = (first_row > 0) ? first_row - 1 : 0;
                seg_end   = last_row;
                // bottom margin only when the run stops above the last row
                if (rows_done >= 1 && seg_end < int'(rows_done) - 1)
                    seg_end++;
                expect_segment(1'b1, seg_start, seg_end - seg_start, 1'b1);
            end else begin
                expect_segment(1'b0, 0, 0, 1'b1);
            end
            clear_frame_state();
        end
    endfunction

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DARK_THRESHOLD: dark_thr   = data[PIX_W-1:0];
            CFG_MIN_SPAN_INNER: span_inner = data;
            CFG_MIN_SPAN_FINAL: span_final = data;
            default: ;
        endcase
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic row_end,
                              input logic frame_end);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pixel     <= pix;
        i_row_end   <= row_end;
        i_frame_end <= frame_end;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pixels_sent++;
        predict_pixel(pix, row_end, frame_end);
    endtask

    // one row; a dark row gets one pixel below the threshold, noise rows are fully random
    task automatic send_row(input logic dark, input logic noisy, input int width,
                            input logic ends_frame, input logic marks_row_end);
        int dark_col;
        logic [PIX_W-1:0] pix;
        dark_col = $urandom_range(0, width - 1);
        for (int c = 0; c < width; c++) begin
            if (noisy)
                pix = PIX_W'($urandom_range(0, 255));
            else if (dark && c == dark_col && dark_thr != PIX_WHITE)
                pix = PIX_W'($urandom_range(0, 254 - int'(dark_thr)));
            else
                pix = PIX_W'($urandom_range(255 - int'(dark_thr), 255));
            send_pixel(pix, (c == width - 1) && marks_row_end, (c == width - 1) && ends_frame);
        end
    endtask

    task automatic send_frame(input int n_rows);
        int width;
        int run_left;
        logic dark;
        logic noisy;
        dark     = 1'($urandom_range(0, 1));
        run_left = $urandom_range(1, 8);
        for (int r = 0; r < n_rows; r++) begin
            width = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1;
            noisy = ($urandom_range(0, 9) == 0);
            if (r == n_rows - 1)
                // sometimes the frame ends in the middle of a row
                send_row(dark, noisy, width, 1'b1, $urandom_range(0, 3) != 0);
            else
                send_row(dark, noisy, width, 1'b0, 1'b1);
            run_left--;
            if (run_left == 0) begin
                dark     = ~dark;
                run_left = $urandom_range(1, 8);
            end
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_segments.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b0);
        for (int r = 1; r <= 10; r++)
            send_row(1'b1, 1'b0, 1, 1'b0, 1'b1);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_row(1'b1, 1'b0, 1, 1'b0, 1'b1);
        // exactly at the threshold is bright, one below is dark
        send_pixel(8'd155, 1'b1, 1'b0);
        send_pixel(8'd154, 1'b1, 1'b0);
        // frame end with no row end
        send_pixel(8'd155, 1'b0, 1'b1);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        write_register(CFG_DARK_THRESHOLD, 12'hFFF);
        write_register(CFG_MIN_SPAN_INNER, 12'd0);
        write_register(CFG_MIN_SPAN_FINAL, 12'd0);
        write_register(CFG_UNUSED_INDEX, 12'd0);
        repeat (3) send_pixel(8'd0, 1'b1, 1'b0);
        send_pixel(8'd0, 1'b1, 1'b1);
        wait_idle();

        write_register(CFG_DARK_THRESHOLD, 12'd0);
        send_pixel(8'd254, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_pixel(8'd254, 1'b1, 1'b0);
        send_pixel(8'd254, 1'b1, 1'b0);
        send_pixel(8'd255, 1'b1, 1'b1);
        wait_idle();

        write_register(CFG_MIN_SPAN_INNER, 12'hFFF);
        write_register(CFG_MIN_SPAN_FINAL, 12'hFFF);
        for (int r = 0; r < 12; r++)
            send_row(1'b1, 1'b0, 1, 1'b0, 1'b1);
        send_pixel(8'd255, 1'b1, 1'b0);
        send_row(1'b1, 1'b0, 1, 1'b0, 1'b1);
        send_pixel(8'd0, 1'b1, 1'b1);
        wait_idle();
    endtask

    // more rows than the block classifies; the rows past the limit are dark but ignored
    task automatic test_row_overflow();
        write_register(CFG_DARK_THRESHOLD, 12'd100);
        write_register(CFG_MIN_SPAN_INNER, 12'd7);
        write_register(CFG_MIN_SPAN_FINAL, 12'd5);
        for (int r = 0; r < MAX_ROWS + 12; r++)
            send_row((r >= 100 && r <= 120) || r >= MAX_ROWS - 18, 1'b0, 1,
                     r == MAX_ROWS + 11, 1'b1);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int thr, input int min_inner,
                                       input int min_final);
        int start_count;
        write_register(CFG_DARK_THRESHOLD, CFG_DAT_W'(thr));
        write_register(CFG_MIN_SPAN_INNER, CFG_DAT_W'(min_inner));
        write_register(CFG_MIN_SPAN_FINAL, CFG_DAT_W'(min_final));
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        start_count        = pixels_sent;
        while (pixels_sent - start_count < PHASE_PIXELS)
            send_frame($urandom_range(1, 30));
        wait_idle();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial begin
        dark_thr   = RST_DARK_THRESHOLD;
        span_inner = RST_MIN_SPAN_INNER;
        span_final = RST_MIN_SPAN_FINAL;
        clear_frame_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_row_overflow();
        test_random_traffic(0, 0, 100, 3, 2);
        test_random_traffic(75, 0, 150, 0, 1);
        test_random_traffic(0, 75, 60, 5, 3);
        test_random_traffic(30, 30, $urandom_range(20, 230), $urandom_range(0, 6),
                            $urandom_range(0, 6));

        repeat (8) @(posedge i_clk);
        mismatch_count += expected_segments.size();
        if (mismatch_count == 0)
            $display("PASS text_line_row_segmenter");
        else
            $display("FAIL text_line_row_segmenter");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tlrs_pkg.sv
rtl/core/tlrs_front.sv
rtl/core/tlrs_queue.sv
rtl/core/tlrs_back.sv
rtl/core/text_line_row_segmenter.sv
tb/testbench.sv
